// File: src/pmsm_mras_speed_observer_core_defines.svh
// Assertion macros for the PMSM MRAS speed observer checker.
// Every macro samples on the rising edge of clock and is disabled in reset.
`ifndef PMSM_MRAS_SPEED_OBSERVER_CORE_DEFINES_SVH
`define PMSM_MRAS_SPEED_OBSERVER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PMSM_MRAS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PMSM_MRAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/pmsm_mras_pkg.sv
// Shared types, constants, saturation helpers and the microprogram ROM of the
// PMSM MRAS speed observer. No dependencies.
package pmsm_mras_pkg;

   localparam int DEF_FRAC_BITS = 16;

   localparam int DATA_W    = 32;
   localparam int INT_W     = 48;
   localparam int OPND_W    = DATA_W + 1;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int ACC_W     = PROD_W;
   localparam int INT_SPLIT = 16;
   localparam int SHIFT_HALF = 16;
   localparam int SHIFT_WORD = 32;

   localparam logic signed [OPND_W-1:0] OPND_ONE   = OPND_W'(1);
   localparam logic signed [OPND_W-1:0] OPND_SPLIT = OPND_W'(2 ** INT_SPLIT);
   // round(2^32 / (2*pi)), turns per radian in Q0.32
   localparam logic signed [OPND_W-1:0] OPND_K2PI  = OPND_W'(683565276);

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_RESIST_INDUCT = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_INDUCT    = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_FLUX_INDUCT   = CSR_INDEX_W'(5);

   localparam int UCODE_LEN = 35;
   localparam int STEP_W    = $clog2(UCODE_LEN);
   localparam logic [STEP_W-1:0] STEP_IDLE = '0;

   typedef struct packed {
      logic [DATA_W-1:0] prop_gain;
      logic [DATA_W-1:0] integ_gain;
      logic [DATA_W-1:0] sample_period;
      logic [DATA_W-1:0] resist_over_induct;
      logic [DATA_W-1:0] inv_induct;
      logic [DATA_W-1:0] flux_over_induct;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] volt_d;
      logic signed [DATA_W-1:0] volt_q;
      logic signed [DATA_W-1:0] cur_d;
      logic signed [DATA_W-1:0] cur_q;
   } sample_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] speed;
      logic [DATA_W-1:0]        angle;
      logic signed [DATA_W-1:0] cur_d;
      logic signed [DATA_W-1:0] cur_q;
   } est_type;

   typedef enum logic [4:0] {
      OPD_ZERO, OPD_ONE, OPD_SPLIT, OPD_K2PI,
      OPD_ROL, OPD_INVL, OPD_FOL, OPD_KP, OPD_KI, OPD_TS,
      OPD_VD, OPD_VQ, OPD_CD, OPD_CQ,
      OPD_ID, OPD_IQ, OPD_SPD, OPD_ERR, OPD_TURN, OPD_ANGLE,
      OPD_TD_LO, OPD_TD_HI, OPD_TQ_LO, OPD_TQ_HI, OPD_INT_LO, OPD_INT_HI
   } opnd_type;

   typedef enum logic [2:0] {
      ACC_NOP, ACC_SET, ACC_NEG, ACC_ADD, ACC_SUB, ACC_SHR
   } acc_op_type;

   typedef enum logic [1:0] {
      SH_0, SH_HALF, SH_WORD, SH_FRAC
   } shift_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_TD, DST_TQ, DST_ID, DST_IQ, DST_ERR, DST_INT,
      DST_SPD, DST_TURN, DST_ANGLE
   } dest_type;

   typedef enum logic [1:0] {
      SEQ_NEXT, SEQ_WAIT_REQ, SEQ_WAIT_RSP
   } seq_type;

   // one control word: issue opa*opb, fold the previous product into the
   // accumulator, and store the accumulator as it stood at step start
   typedef struct packed {
      opnd_type          opa;
      opnd_type          opb;
      acc_op_type        acc_op;
      shift_type         shift;
      dest_type          dest;
      seq_type           seq;
      logic [STEP_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_free;
   } seq_cond_type;

   typedef struct packed {
      logic idle;
      logic emit;
   } seq_flags_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if ((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1])) begin
         r = x[DATA_W-1:0];
      end else begin
         r = x[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [INT_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
      logic signed [INT_W-1:0] r;
      if ((&x[ACC_W-1:INT_W-1]) || !(|x[ACC_W-1:INT_W-1])) begin
         r = x[INT_W-1:0];
      end else begin
         r = x[ACC_W-1] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic uword_type uw(input opnd_type a, input opnd_type b,
                                    input acc_op_type op, input shift_type sh,
                                    input dest_type d);
      uword_type w;
      w.opa    = a;
      w.opb    = b;
      w.acc_op = op;
      w.shift  = sh;
      w.dest   = d;
      w.seq    = SEQ_NEXT;
      w.target = STEP_IDLE;
      return w;
   endfunction

   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      unique case (step)
         // wait for a beat
         0: begin
            w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, DST_NONE);
            w.seq = SEQ_WAIT_REQ;
         end
         // d derivative: w*iq - rol*id + invl*vd
         1:  w = uw(OPD_SPD,   OPD_IQ,    ACC_NOP, SH_0,    DST_NONE);
         2:  w = uw(OPD_ROL,   OPD_ID,    ACC_SET, SH_FRAC, DST_NONE);
         3:  w = uw(OPD_INVL,  OPD_VD,    ACC_SUB, SH_FRAC, DST_NONE);
         4:  w = uw(OPD_INVL,  OPD_VQ,    ACC_ADD, SH_FRAC, DST_NONE);
         // q derivative: invl*vq - w*id - rol*iq
         5:  w = uw(OPD_SPD,   OPD_ID,    ACC_SET, SH_FRAC, DST_TD);
         6:  w = uw(OPD_ROL,   OPD_IQ,    ACC_SUB, SH_FRAC, DST_NONE);
         // Euler step, derivative split in two halves against Ts
         7:  w = uw(OPD_TD_LO, OPD_TS,    ACC_SUB, SH_FRAC, DST_NONE);
         8:  w = uw(OPD_TD_HI, OPD_TS,    ACC_SET, SH_WORD, DST_TQ);
         9:  w = uw(OPD_ID,    OPD_ONE,   ACC_ADD, SH_0,    DST_NONE);
         10: w = uw(OPD_TQ_LO, OPD_TS,    ACC_ADD, SH_0,    DST_NONE);
         11: w = uw(OPD_TQ_HI, OPD_TS,    ACC_SET, SH_WORD, DST_ID);
         12: w = uw(OPD_IQ,    OPD_ONE,   ACC_ADD, SH_0,    DST_NONE);
         13: w = uw(OPD_FOL,   OPD_CQ,    ACC_ADD, SH_0,    DST_NONE);
         // adaptation error
         14: w = uw(OPD_ID,    OPD_CQ,    ACC_NEG, SH_FRAC, DST_IQ);
         15: w = uw(OPD_CD,    OPD_IQ,    ACC_SUB, SH_FRAC, DST_NONE);
         16: w = uw(OPD_FOL,   OPD_IQ,    ACC_ADD, SH_FRAC, DST_NONE);
         17: w = uw(OPD_INT_HI, OPD_SPLIT, ACC_ADD, SH_FRAC, DST_NONE);
         // integral
         18: w = uw(OPD_INT_LO, OPD_ONE,  ACC_SET, SH_0,    DST_ERR);
         19: w = uw(OPD_ERR,   OPD_TS,    ACC_ADD, SH_0,    DST_NONE);
         20: w = uw(OPD_ZERO,  OPD_ZERO,  ACC_ADD, SH_HALF, DST_NONE);
         21: w = uw(OPD_ZERO,  OPD_ZERO,  ACC_NOP, SH_0,    DST_INT);
         // PI law, integral term split at bit 16
         22: w = uw(OPD_INT_LO, OPD_KI,   ACC_NOP, SH_0,    DST_NONE);
         23: w = uw(OPD_INT_HI, OPD_KI,   ACC_SET, SH_HALF, DST_NONE);
         24: w = uw(OPD_ZERO,  OPD_ZERO,  ACC_ADD, SH_0,    DST_NONE);
         25: w = uw(OPD_KP,    OPD_ERR,   ACC_SHR, SH_0,    DST_NONE);
         26: w = uw(OPD_ZERO,  OPD_ZERO,  ACC_ADD, SH_FRAC, DST_NONE);
         27: w = uw(OPD_ZERO,  OPD_ZERO,  ACC_NOP, SH_0,    DST_SPD);
         // angle integration
         28: w = uw(OPD_SPD,   OPD_K2PI,  ACC_NOP, SH_0,    DST_NONE);
         29: w = uw(OPD_ANGLE, OPD_ONE,   ACC_SET, SH_WORD, DST_NONE);
         30: w = uw(OPD_ZERO,  OPD_ZERO,  ACC_SET, SH_0,    DST_TURN);
         31: w = uw(OPD_TURN,  OPD_TS,    ACC_NOP, SH_0,    DST_NONE);
         32: w = uw(OPD_ZERO,  OPD_ZERO,  ACC_ADD, SH_FRAC, DST_NONE);
         33: w = uw(OPD_ZERO,  OPD_ZERO,  ACC_NOP, SH_0,    DST_ANGLE);
         // hand the result over, hold while the output register is full and stalled
         34: begin
            w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, DST_NONE);
            w.seq    = SEQ_WAIT_RSP;
            w.target = STEP_IDLE;
         end
         default: begin
            w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, DST_NONE);
            w.seq    = SEQ_WAIT_RSP;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: src/pmsm_mras_seq.sv
// Microprogram sequencer: step counter, control ROM lookup and jumps.
// Depends on pmsm_mras_pkg.
module pmsm_mras_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  pmsm_mras_pkg::seq_cond_type  cond,
   output pmsm_mras_pkg::uword_type     ctrl,
   output pmsm_mras_pkg::seq_flags_type flags
);
   import pmsm_mras_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   uword_type         word;

   assign word = ucode(step_ff);
   assign ctrl = word;

   assign flags.idle = (word.seq == SEQ_WAIT_REQ);
   assign flags.emit = (word.seq == SEQ_WAIT_RSP) && cond.rsp_free;

   always_comb begin
      unique case (word.seq)
         SEQ_NEXT:     step_in = STEP_W'(step_ff + 1'b1);
         SEQ_WAIT_REQ: step_in = cond.req_valid ? STEP_W'(step_ff + 1'b1) : step_ff;
         SEQ_WAIT_RSP: step_in = cond.rsp_free ? word.target : step_ff;
         default:      step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: src/pmsm_mras_dp.sv
// Observer datapath: operand select, shared 33x33 multiplier, wide
// accumulator and the observer state. Depends on pmsm_mras_pkg.
module pmsm_mras_dp #(
   parameter int FRAC_BITS = pmsm_mras_pkg::DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pmsm_mras_pkg::uword_type  ctrl,
   input  pmsm_mras_pkg::cfg_type    cfg,
   input  pmsm_mras_pkg::sample_type smp,
   output pmsm_mras_pkg::est_type    est
);
   import pmsm_mras_pkg::*;

   // current derivative: three products of < 2^63, each shifted by FRAC_BITS
   localparam int DERIV_W = 66 - FRAC_BITS;
   localparam int HI_W    = DERIV_W - DATA_W;

   logic signed [PROD_W-1:0]  prod_ff, prod_in, prod_sh;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [OPND_W-1:0]  a_val, b_val;

   logic signed [DERIV_W-1:0] td_ff, td_in, tq_ff, tq_in;
   logic signed [DATA_W-1:0]  err_ff, err_in, turn_ff, turn_in;
   logic signed [DATA_W-1:0]  id_ff, id_in, iq_ff, iq_in, spd_ff, spd_in;
   logic [DATA_W-1:0]         angle_ff, angle_in;
   logic signed [INT_W-1:0]   int_ff, int_in;

   function automatic logic signed [OPND_W-1:0] pick(input opnd_type sel);
      logic signed [OPND_W-1:0] v;
      unique case (sel)
         OPD_ZERO:   v = '0;
         OPD_ONE:    v = OPND_ONE;
         OPD_SPLIT:  v = OPND_SPLIT;
         OPD_K2PI:   v = OPND_K2PI;
         OPD_ROL:    v = {1'b0, cfg.resist_over_induct};
         OPD_INVL:   v = {1'b0, cfg.inv_induct};
         OPD_FOL:    v = {1'b0, cfg.flux_over_induct};
         OPD_KP:     v = {1'b0, cfg.prop_gain};
         OPD_KI:     v = {1'b0, cfg.integ_gain};
         OPD_TS:     v = {1'b0, cfg.sample_period};
         OPD_VD:     v = {smp.volt_d[DATA_W-1], smp.volt_d};
         OPD_VQ:     v = {smp.volt_q[DATA_W-1], smp.volt_q};
         OPD_CD:     v = {smp.cur_d[DATA_W-1], smp.cur_d};
         OPD_CQ:     v = {smp.cur_q[DATA_W-1], smp.cur_q};
         OPD_ID:     v = {id_ff[DATA_W-1], id_ff};
         OPD_IQ:     v = {iq_ff[DATA_W-1], iq_ff};
         OPD_SPD:    v = {spd_ff[DATA_W-1], spd_ff};
         OPD_ERR:    v = {err_ff[DATA_W-1], err_ff};
         OPD_TURN:   v = {turn_ff[DATA_W-1], turn_ff};
         OPD_ANGLE:  v = {1'b0, angle_ff};
         OPD_TD_LO:  v = {1'b0, td_ff[DATA_W-1:0]};
         OPD_TD_HI:  v = {{(OPND_W-HI_W){td_ff[DERIV_W-1]}}, td_ff[DERIV_W-1:DATA_W]};
         OPD_TQ_LO:  v = {1'b0, tq_ff[DATA_W-1:0]};
         OPD_TQ_HI:  v = {{(OPND_W-HI_W){tq_ff[DERIV_W-1]}}, tq_ff[DERIV_W-1:DATA_W]};
         OPD_INT_LO: v = {{(OPND_W-INT_SPLIT){1'b0}}, int_ff[INT_SPLIT-1:0]};
         OPD_INT_HI: v = {int_ff[INT_W-1], int_ff[INT_W-1:INT_SPLIT]};
         default:    v = '0;
      endcase
      return v;
   endfunction

   // operand values change under a fixed selector too, so track them all
   always_comb begin
      a_val = pick(ctrl.opa);
      b_val = pick(ctrl.opb);
   end

   assign prod_in = PROD_W'(a_val) * PROD_W'(b_val);

   // floor shift of the product issued in the previous step
   always_comb begin
      unique case (ctrl.shift)
         SH_0:    prod_sh = prod_ff;
         SH_HALF: prod_sh = prod_ff >>> SHIFT_HALF;
         SH_WORD: prod_sh = prod_ff >>> SHIFT_WORD;
         SH_FRAC: prod_sh = prod_ff >>> FRAC_BITS;
         default: prod_sh = prod_ff;
      endcase
   end

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_NOP: acc_in = acc_ff;
         ACC_SET: acc_in = prod_sh;
         ACC_NEG: acc_in = -prod_sh;
         ACC_ADD: acc_in = acc_ff + prod_sh;
         ACC_SUB: acc_in = acc_ff - prod_sh;
         ACC_SHR: acc_in = acc_ff >>> FRAC_BITS;
         default: acc_in = acc_ff;
      endcase
   end

   always_comb begin
      td_in    = td_ff;
      tq_in    = tq_ff;
      err_in   = err_ff;
      turn_in  = turn_ff;
      id_in    = id_ff;
      iq_in    = iq_ff;
      spd_in   = spd_ff;
      angle_in = angle_ff;
      int_in   = int_ff;
      unique case (ctrl.dest)
         DST_NONE:  ;
         DST_TD:    td_in    = acc_ff[DERIV_W-1:0];
         DST_TQ:    tq_in    = acc_ff[DERIV_W-1:0];
         DST_ID:    id_in    = sat32(acc_ff);
         DST_IQ:    iq_in    = sat32(acc_ff);
         DST_ERR:   err_in   = sat32(acc_ff);
         DST_INT:   int_in   = sat48(acc_ff);
         DST_SPD:   spd_in   = sat32(acc_ff);
         DST_TURN:  turn_in  = acc_ff[DATA_W-1:0];
         DST_ANGLE: angle_in = acc_ff[DATA_W-1:0];
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      td_ff   <= td_in;
      tq_ff   <= tq_in;
      err_ff  <= err_in;
      turn_ff <= turn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff    <= '0;
         iq_ff    <= '0;
         spd_ff   <= '0;
         angle_ff <= '0;
         int_ff   <= '0;
      end else begin
         id_ff    <= id_in;
         iq_ff    <= iq_in;
         spd_ff   <= spd_in;
         angle_ff <= angle_in;
         int_ff   <= int_in;
      end
   end

   assign est.speed = spd_ff;
   assign est.angle = angle_ff;
   assign est.cur_d = id_ff;
   assign est.cur_q = iq_ff;

endmodule

// File: src/pmsm_mras_speed_observer_core.sv
// Sensorless PMSM speed observer (MRAS) top level: config registers, input
// capture, output register. Depends on pmsm_mras_pkg, pmsm_mras_seq, pmsm_mras_dp.
//
// One beat of measured dq voltages and currents yields one beat of speed,
// angle and model currents. A 35-step microprogram drives a single shared
// 33x33 multiplier, one product per step, into a 66-bit accumulator; the
// result is registered at the last step, and the sequencer is back at idle
// in the cycle in which that result appears; beats are taken one at a time.
// req_stall is high while the program runs; the next beat is accepted even
// while the previous result still sits in the output register, but the
// program holds at its last step until that register is free. Write the
// configuration registers only while the block is idle. FRAC_BITS sets the
// fraction width of the Q formats, but the constant K2PI stays Q0.32.
module pmsm_mras_speed_observer_core #(
   parameter int FRAC_BITS = pmsm_mras_pkg::DEF_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [31:0]                     req_volt_d,
   input  logic signed [31:0]                     req_volt_q,
   input  logic signed [31:0]                     req_cur_d,
   input  logic signed [31:0]                     req_cur_q,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [31:0]                     rsp_speed_out,
   output logic [31:0]                            rsp_angle_out,
   output logic signed [31:0]                     rsp_cur_d_model,
   output logic signed [31:0]                     rsp_cur_q_model,
   input  logic                                   csr_we,
   input  logic [pmsm_mras_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                            csr_wdata
);
   import pmsm_mras_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   sample_type    smp_ff;
   est_type       est;
   est_type       rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   uword_type     ctrl;
   seq_cond_type  cond;
   seq_flags_type flags;
   logic          req_take;

   assign req_stall = !flags.idle;
   assign req_take  = req_valid && flags.idle;

   assign cond.req_valid = req_valid;
   assign cond.rsp_free  = !rsp_valid_ff || !rsp_stall;

   pmsm_mras_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl),
      .flags (flags)
   );

   pmsm_mras_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .cfg   (cfg_ff),
      .smp   (smp_ff),
      .est   (est)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:     cfg_in.prop_gain          = csr_wdata;
            CSR_INTEG_GAIN:    cfg_in.integ_gain         = csr_wdata;
            CSR_SAMPLE_PERIOD: cfg_in.sample_period      = csr_wdata;
            CSR_RESIST_INDUCT: cfg_in.resist_over_induct = csr_wdata;
            CSR_INV_INDUCT:    cfg_in.inv_induct         = csr_wdata;
            CSR_FLUX_INDUCT:   cfg_in.flux_over_induct   = csr_wdata;
            default:           ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (flags.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         smp_ff.volt_d <= req_volt_d;
         smp_ff.volt_q <= req_volt_q;
         smp_ff.cur_d  <= req_cur_d;
         smp_ff.cur_q  <= req_cur_q;
      end
      if (flags.emit) begin
         rsp_ff <= est;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_out   = rsp_ff.speed;
   assign rsp_angle_out   = rsp_ff.angle;
   assign rsp_cur_d_model = rsp_ff.cur_d;
   assign rsp_cur_q_model = rsp_ff.cur_q;

endmodule

// File: src/pmsm_mras_chk.sv
// Port-level checker for the PMSM MRAS speed observer, bound to the top level.
// Depends on pmsm_mras_speed_observer_core_defines.svh.
`include "pmsm_mras_speed_observer_core_defines.svh"

module pmsm_mras_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_speed_out,
   input logic [31:0] rsp_angle_out
);

   // an accepted beat starts the program, which blocks further beats
   `PMSM_MRAS_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall, "input accepted while busy")

   // no result can appear right after a beat is taken
   `PMSM_MRAS_ASSERT_NEXT(a_no_instant_rsp, req_valid && !req_stall, !$rose(rsp_valid), "result too early")

   // a new result is loaded from the last step, which then returns to idle
   `PMSM_MRAS_ASSERT_NOW(a_rsp_from_last_step, $rose(rsp_valid), !req_stall && $past(req_stall), "result outside program end")

   `PMSM_MRAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_speed_out) && $stable(rsp_angle_out), "stalled result changed")

endmodule

bind pmsm_mras_speed_observer_core pmsm_mras_chk u_chk (.*);
